// ===== sv/rfnb_pkg.sv =====
// ----------------------------------------------------------------------------
// rfnb_pkg
// Shared types, constants and helpers for the four-neighbour RGB blur core.
// ----------------------------------------------------------------------------
package rfnb_pkg;

	// channel and pixel geometry
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int PIX_W   = CH_W * NUM_CH;
	// sum of up to four channel values
	localparam int SUM_W   = CH_W + 2;

	// exact divide by three: floor(x / 3) == (x * DIV3_MULT) >> DIV3_SHIFT for x < 2**SUM_W
	localparam int DIV3_SHIFT = SUM_W + 2;
	localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;
	localparam int PROD_W     = SUM_W + DIV3_SHIFT;

	// default sizes of the line stores and row counter
	localparam int MAX_WIDTH_DEFAULT  = 1024;
	localparam int MAX_HEIGHT_DEFAULT = 1024;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DIM_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RESET  = CFG_DIM_W'(428);
	localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RESET = CFG_DIM_W'(521);

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// divisor codes
	localparam logic [1:0] DIV_BY_4 = 2'd0;
	localparam logic [1:0] DIV_BY_3 = 2'd1;
	localparam logic [1:0] DIV_BY_2 = 2'd2;

	// pixel as channel vector: 0 red, 1 green, 2 blue
	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

	// input item
	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic            flush;
	} item_in_t;

	// result item
	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            frame_end;
	} item_out_t;

	// which neighbours fall outside the frame
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} edges_t;

	// one blur job handed from front to back
	typedef struct packed {
		pix_t   up;
		pix_t   down;
		pix_t   left;
		pix_t   right;
		edges_t edges;
		logic   frame_end;
	} job_t;

	// clamp a frame dimension to [2, hi]
	function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v, input int hi);
		int r;
		r = int'(v);
		if (r < 2) begin
			r = 2;
		end else if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ===== sv/rgb_four_neighbour_blur_core.sv =====
// ----------------------------------------------------------------------------
// rgb_four_neighbour_blur_core
// One pass of a four-neighbour mean blur over an RGB frame in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel: one pixel per item, raster order. Each output pixel is the
//   truncated mean of its up, down, left and right neighbours inside the
//   frame. Results lag one row: the item at row r+1, column c releases the
//   result for row r, column c. After the last row, frame_width items with
//   flush set release the bottom row; frame_end marks its last pixel, and the
//   next item starts a new frame. Flush items during the input rows are
//   taken and dropped.
//   res channel: one result item per releasing item, in order.
//   cfg channel: always ready; index 0 frame_width, 1 frame_height, both
//   clamped to [2, MAX_*]. A write restarts the frame; write only when idle.
// Timing: one item per cycle sustained while pix_stall is low. A result is
//   registered at store read, queue, sum and divide (output register) after
//   its item. Throughput is set by each line store's read/write port pair.
// Reset: frame restarts at row 0, sizes 428 x 521, no result pending.
// Stall: a stalled result holds in the output register; the four-entry job
//   queue absorbs the pipeline, then pix_stall rises until space frees up.
// ----------------------------------------------------------------------------
module rgb_four_neighbour_blur_core #(
	parameter int MAX_WIDTH  = rfnb_pkg::MAX_WIDTH_DEFAULT,
	parameter int MAX_HEIGHT = rfnb_pkg::MAX_HEIGHT_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  rfnb_pkg::item_in_t              pix_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output rfnb_pkg::item_out_t             res_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rfnb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfnb_pkg::CFG_DIM_W-1:0]  cfg_data
);

	localparam int DEPTH = rfnb_pkg::QUEUE_DEPTH;
	localparam int LW    = $clog2(DEPTH + 1);

	logic             push;
	logic             pop;
	rfnb_pkg::job_t   push_job;
	rfnb_pkg::job_t   head;
	logic [LW-1:0]    q_level;

	assign cfg_ready = 1'b1;

	// line stores and neighbour gathering
	rfnb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DEPTH      (DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_item  (pix_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_level   (q_level),
		.push      (push),
		.push_job  (push_job)
	);

	// decoupling queue
	rfnb_queue #(.DEPTH(DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.level    (q_level)
	);

	// mean and output register
	rfnb_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_level   (q_level),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

// ===== sv/rfnb_ram.sv =====
// ----------------------------------------------------------------------------
// rfnb_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module rfnb_ram #(
	parameter int WIDTH = rfnb_pkg::PIX_W,
	parameter int DEPTH = rfnb_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== sv/rfnb_queue.sv =====
// ----------------------------------------------------------------------------
// rfnb_queue
// Short job queue that decouples the front (line stores) from the back (math).
// ----------------------------------------------------------------------------
module rfnb_queue #(
	parameter int DEPTH = rfnb_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rfnb_pkg::job_t             push_job,
	input  logic                       pop,
	output rfnb_pkg::job_t             head,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH+1);

	rfnb_pkg::job_t  slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [LW-1:0]   level_q;

	assign head  = slot_q[rd_ptr_q];
	assign level = level_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

// ===== sv/rfnb_front.sv =====
// ----------------------------------------------------------------------------
// rfnb_front
// Accepts pixels, tracks row and column, keeps the three line stores and
// gathers the four neighbours of each released pixel into a job.
// ----------------------------------------------------------------------------
module rfnb_front #(
	parameter int MAX_WIDTH  = rfnb_pkg::MAX_WIDTH_DEFAULT,
	parameter int MAX_HEIGHT = rfnb_pkg::MAX_HEIGHT_DEFAULT,
	parameter int DEPTH      = rfnb_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  rfnb_pkg::item_in_t                 pix_item,
	input  logic                               cfg_valid,
	input  logic [rfnb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rfnb_pkg::CFG_DIM_W-1:0]     cfg_data,
	input  logic [$clog2(DEPTH+1)-1:0]         q_level,
	output logic                               push,
	output rfnb_pkg::job_t                     push_job
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int LW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_COL_RESET =
		AW'(rfnb_pkg::clamp_dim(rfnb_pkg::FRAME_WIDTH_RESET, MAX_WIDTH) - 1);
	localparam logic [RW-1:0] HEIGHT_RESET =
		RW'(rfnb_pkg::clamp_dim(rfnb_pkg::FRAME_HEIGHT_RESET, MAX_HEIGHT));

	logic [AW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [AW-1:0]       last_col_q;
	logic [RW-1:0]       height_q;
	logic                drain;
	logic                at_right;
	logic                accept;
	logic                go;
	logic                cfg_w_hit;
	logic                cfg_h_hit;
	logic [LW:0]         fill;
	rfnb_pkg::pix_t      pix;
	rfnb_pkg::pix_t      above_rd;
	rfnb_pkg::pix_t      ctr_here_rd;
	rfnb_pkg::pix_t      ctr_next_rd;
	rfnb_pkg::pix_t      left_q;
	logic                valid_s1;
	logic                emit_s1;
	logic                wr_above_s1;
	logic [AW-1:0]       col_s1;
	rfnb_pkg::pix_t      down_s1;
	rfnb_pkg::edges_t    edges_s1;
	logic                frame_end_s1;

	// credit check: an accepted item must find room in the queue when stage 1 pushes it
	assign fill      = {1'b0, q_level} + {{LW{1'b0}}, valid_s1};
	assign pix_stall = (fill >= (LW+1)'(DEPTH));
	assign accept    = pix_valid && !pix_stall;

	// classify the item
	assign drain    = (row_q == height_q);
	assign at_right = (col_q == last_col_q);
	assign go       = accept && (drain || !pix_item.flush);

	assign pix[0] = pix_item.red_in;
	assign pix[1] = pix_item.green_in;
	assign pix[2] = pix_item.blue_in;

	assign cfg_w_hit = cfg_valid && (cfg_index == rfnb_pkg::CFG_FRAME_WIDTH);
	assign cfg_h_hit = cfg_valid && (cfg_index == rfnb_pkg::CFG_FRAME_HEIGHT);

	// row two above: read at acceptance, written from stage 1 with the old centre word
	rfnb_ram #(.WIDTH(rfnb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_above (
		.clk   (clk),
		.we    (valid_s1 && wr_above_s1),
		.waddr (col_s1),
		.wdata (ctr_here_rd),
		.re    (go),
		.raddr (col_q),
		.rdata (above_rd)
	);

	// row just above, copy read at the current column
	rfnb_ram #(.WIDTH(rfnb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_centre_here (
		.clk   (clk),
		.we    (go && !drain),
		.waddr (col_q),
		.wdata (pix),
		.re    (go),
		.raddr (col_q),
		.rdata (ctr_here_rd)
	);

	// row just above, copy read at the next column
	rfnb_ram #(.WIDTH(rfnb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_centre_next (
		.clk   (clk),
		.we    (go && !drain),
		.waddr (col_q),
		.wdata (pix),
		.re    (go),
		.raddr (col_q + AW'(1)),
		.rdata (ctr_next_rd)
	);

	// frame geometry and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			last_col_q <= LAST_COL_RESET;
			height_q   <= HEIGHT_RESET;
		end else if (cfg_w_hit || cfg_h_hit) begin
			if (cfg_w_hit) begin
				last_col_q <= AW'(rfnb_pkg::clamp_dim(cfg_data, MAX_WIDTH) - 1);
			end
			if (cfg_h_hit) begin
				height_q <= RW'(rfnb_pkg::clamp_dim(cfg_data, MAX_HEIGHT));
			end
			col_q <= '0;
			row_q <= '0;
		end else if (go) begin
			if (at_right) begin
				col_q <= '0;
				row_q <= drain ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// stage 1 control, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= go;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (go) begin
			emit_s1         <= drain || (row_q != '0);
			wr_above_s1     <= !drain;
			col_s1          <= col_q;
			down_s1         <= drain ? '0 : pix;
			edges_s1.top    <= !drain && (row_q == RW'(1));
			edges_s1.bottom <= drain;
			edges_s1.left   <= (col_q == '0);
			edges_s1.right  <= at_right;
			frame_end_s1    <= drain && at_right;
		end
	end

	// left neighbour is the centre word of the previous column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (cfg_w_hit || cfg_h_hit) begin
			left_q <= '0;
		end else if (valid_s1) begin
			left_q <= ctr_here_rd;
		end
	end

	// job to the queue
	assign push               = valid_s1 && emit_s1;
	assign push_job.up        = above_rd;
	assign push_job.down      = down_s1;
	assign push_job.left      = left_q;
	assign push_job.right     = ctr_next_rd;
	assign push_job.edges     = edges_s1;
	assign push_job.frame_end = frame_end_s1;

endmodule

// ===== sv/rfnb_back.sv =====
// ----------------------------------------------------------------------------
// rfnb_back
// Sums the in-frame neighbours, divides by their count and holds the result
// item in the output register.
// ----------------------------------------------------------------------------
module rfnb_back #(
	parameter int DEPTH = rfnb_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rfnb_pkg::job_t             head,
	input  logic [$clog2(DEPTH+1)-1:0] q_level,
	output logic                       pop,
	output logic                       res_valid,
	input  logic                       res_stall,
	output rfnb_pkg::item_out_t        res_item
);

	localparam int SW = rfnb_pkg::SUM_W;
	localparam int PW = rfnb_pkg::PROD_W;
	localparam int CW = rfnb_pkg::CH_W;

	logic                                  out_take;
	logic                                  sum_take;
	logic [2:0]                            n_edges;
	logic [1:0]                            div_code;
	logic [rfnb_pkg::NUM_CH-1:0][SW-1:0]   sum;
	logic [rfnb_pkg::NUM_CH-1:0][CW-1:0]   quot;
	logic                                  valid_s1;
	logic [rfnb_pkg::NUM_CH-1:0][SW-1:0]   sum_s1;
	logic [1:0]                            div_s1;
	logic                                  frame_end_s1;
	logic                                  res_valid_q;
	rfnb_pkg::item_out_t                   res_item_q;

	// pipeline advance
	assign out_take = !res_valid_q || !res_stall;
	assign sum_take = !valid_s1 || out_take;
	assign pop      = (q_level != '0) && sum_take;

	// masked neighbour sums
	always_comb begin
		for (int k = 0; k < rfnb_pkg::NUM_CH; k++) begin
			sum[k] = (head.edges.top    ? '0 : SW'(head.up[k]))
			       + (head.edges.bottom ? '0 : SW'(head.down[k]))
			       + (head.edges.left   ? '0 : SW'(head.left[k]))
			       + (head.edges.right  ? '0 : SW'(head.right[k]));
		end
	end

	// divisor from the number of missing neighbours
	assign n_edges = {2'b0, head.edges.top} + {2'b0, head.edges.bottom}
	               + {2'b0, head.edges.left} + {2'b0, head.edges.right};

	always_comb begin
		unique case (n_edges)
			3'd0:    div_code = rfnb_pkg::DIV_BY_4;
			3'd1:    div_code = rfnb_pkg::DIV_BY_3;
			default: div_code = rfnb_pkg::DIV_BY_2;
		endcase
	end

	// sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sum_take) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_s1       <= sum;
			div_s1       <= div_code;
			frame_end_s1 <= head.frame_end;
		end
	end

	// truncated mean per channel
	always_comb begin
		logic [PW-1:0] prod;
		for (int k = 0; k < rfnb_pkg::NUM_CH; k++) begin
			prod = PW'(sum_s1[k]) * PW'(rfnb_pkg::DIV3_MULT);
			unique case (div_s1)
				rfnb_pkg::DIV_BY_4: quot[k] = sum_s1[k][2 +: CW];
				rfnb_pkg::DIV_BY_3: quot[k] = prod[rfnb_pkg::DIV3_SHIFT +: CW];
				default:            quot[k] = sum_s1[k][1 +: CW];
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_take) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s1) begin
			res_item_q.red_out   <= quot[0];
			res_item_q.green_out <= quot[1];
			res_item_q.blue_out  <= quot[2];
			res_item_q.frame_end <= frame_end_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule
